[hw/rtl/pid_controller_periodic_integral_clear_macros.svh]
// Assertion macros for the PID controller with periodic integral clear.
`ifndef PID_CONTROLLER_PERIODIC_INTEGRAL_CLEAR_MACROS_SVH
`define PID_CONTROLLER_PERIODIC_INTEGRAL_CLEAR_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on the rising clock, off during reset.
`define PCIC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcic: same-cycle check failed");
// Next-cycle implication, sampled on the rising clock, off during reset.
`define PCIC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcic: next-cycle check failed");
`else
`define PCIC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define PCIC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/pcic_pkg.sv]
// Package: types, widths and register codes of the PID controller.
`default_nettype none
package pcic_pkg;

  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned ERR_W    = 17;
  localparam int unsigned DIFF_W   = 18;
  localparam int unsigned INTEG_W  = 32;
  localparam int unsigned OUT_W    = 24;
  localparam int unsigned CNT_W    = 9;
  localparam int unsigned PROD_P_W = GAIN_W + ERR_W;
  localparam int unsigned PROD_I_W = GAIN_W + INTEG_W;
  localparam int unsigned PROD_D_W = GAIN_W + DIFF_W;
  localparam int unsigned SUM_W    = PROD_I_W + 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 24;

  localparam int unsigned CLEAR_LIMIT_DEF = 501;
  localparam int unsigned FRAC_BITS_DEF   = 8;

  localparam logic signed [OUT_W-1:0] OUT_MIN_RST = 24'sh800000;
  localparam logic signed [OUT_W-1:0] OUT_MAX_RST = 24'sh7FFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P  = 3'd0,
    REG_GAIN_I  = 3'd1,
    REG_GAIN_D  = 3'd2,
    REG_OUT_MIN = 3'd3,
    REG_OUT_MAX = 3'd4
  } pcic_reg_e;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic signed [OUT_W-1:0]  out_min;
    logic signed [OUT_W-1:0]  out_max;
  } pcic_cfg_t;

endpackage
`default_nettype wire

[hw/rtl/pcic_cfg_regs.sv]
// Configuration register file: gains and clamp limits.
`default_nettype none
module pcic_cfg_regs
  import pcic_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 wr_en_i,
  input  wire logic [CFG_IDX_W-1:0] wr_idx_i,
  input  wire logic [CFG_DAT_W-1:0] wr_data_i,
  output pcic_cfg_t                 cfg_o
);

  pcic_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_idx_i)
        REG_GAIN_P:  cfg_d.gain_p  = wr_data_i[GAIN_W-1:0];
        REG_GAIN_I:  cfg_d.gain_i  = wr_data_i[GAIN_W-1:0];
        REG_GAIN_D:  cfg_d.gain_d  = wr_data_i[GAIN_W-1:0];
        REG_OUT_MIN: cfg_d.out_min = wr_data_i[OUT_W-1:0];
        REG_OUT_MAX: cfg_d.out_max = wr_data_i[OUT_W-1:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p  <= '0;
      cfg_q.gain_i  <= '0;
      cfg_q.gain_d  <= '0;
      cfg_q.out_min <= OUT_MIN_RST;
      cfg_q.out_max <= OUT_MAX_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

[hw/rtl/pcic_front.sv]
// Front stage: error, difference, saturating integral and clear counter.
`default_nettype none
`include "pid_controller_periodic_integral_clear_macros.svh"
module pcic_front
  import pcic_pkg::*;
#(
  parameter int unsigned CLEAR_LIMIT = CLEAR_LIMIT_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       load_i,
  input  wire logic signed [SAMPLE_W-1:0] measured_i,
  input  wire logic signed [SAMPLE_W-1:0] setpoint_i,
  output logic signed [ERR_W-1:0]         err_o,
  output logic signed [DIFF_W-1:0]        diff_o,
  output logic signed [INTEG_W-1:0]       integ_o
);

  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(CLEAR_LIMIT);
  localparam logic signed [INTEG_W:0] SAT_HI = {2'b00, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W:0] SAT_LO = {2'b11, {(INTEG_W-1){1'b0}}};

  logic signed [ERR_W-1:0]   last_err_q, last_err_d;
  logic signed [INTEG_W-1:0] integ_q, integ_d;
  logic [CNT_W-1:0]          count_q, count_d;
  logic signed [ERR_W-1:0]   err_q, err_d;
  logic signed [DIFF_W-1:0]  diff_q, diff_d;
  logic signed [INTEG_W-1:0] integ_use_q;
  logic signed [INTEG_W:0]   acc;

  always_comb begin
    err_d  = ERR_W'(setpoint_i) - ERR_W'(measured_i);
    diff_d = DIFF_W'(last_err_q) - DIFF_W'(err_d);
    acc    = (INTEG_W+1)'(integ_q) + (INTEG_W+1)'(err_d);
    if (acc > SAT_HI) begin
      integ_d = SAT_HI[INTEG_W-1:0];
    end else if (acc < SAT_LO) begin
      integ_d = SAT_LO[INTEG_W-1:0];
    end else begin
      integ_d = acc[INTEG_W-1:0];
    end
    if (count_q < LIMIT) begin
      count_d = count_q + 1'b1;
    end else begin
      count_d = '0;
      integ_d = '0;
    end
    last_err_d = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= '0;
      integ_q    <= '0;
      count_q    <= '0;
    end else if (load_i) begin
      last_err_q <= last_err_d;
      integ_q    <= integ_d;
      count_q    <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      err_q       <= err_d;
      diff_q      <= diff_d;
      integ_use_q <= integ_d;
    end
  end

  assign err_o   = err_q;
  assign diff_o  = diff_q;
  assign integ_o = integ_use_q;

  `PCIC_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= LIMIT)
  `PCIC_ASSERT_NEXT(a_clear_step, clk_i, rst_ni, load_i && count_q >= LIMIT,
                    count_q == '0 && integ_q == '0)
  `PCIC_ASSERT_NEXT(a_count_step, clk_i, rst_ni, load_i && count_q < LIMIT,
                    count_q == $past(count_q) + 1'b1)

endmodule
`default_nettype wire

[hw/rtl/pcic_mult.sv]
// Multiply stage: the three gain products, registered.
`default_nettype none
module pcic_mult
  import pcic_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      load_i,
  input  wire pcic_cfg_t                 cfg_i,
  input  wire logic signed [ERR_W-1:0]   err_i,
  input  wire logic signed [DIFF_W-1:0]  diff_i,
  input  wire logic signed [INTEG_W-1:0] integ_i,
  output logic signed [PROD_P_W-1:0]     prod_p_o,
  output logic signed [PROD_I_W-1:0]     prod_i_o,
  output logic signed [PROD_D_W-1:0]     prod_d_o,
  output logic signed [ERR_W-1:0]        err_o
);

  logic signed [PROD_P_W-1:0] prod_p_q, prod_p_d;
  logic signed [PROD_I_W-1:0] prod_i_q, prod_i_d;
  logic signed [PROD_D_W-1:0] prod_d_q, prod_d_d;
  logic signed [ERR_W-1:0]    err_q;

  always_comb begin
    prod_p_d = PROD_P_W'(cfg_i.gain_p) * PROD_P_W'(err_i);
    prod_i_d = PROD_I_W'(cfg_i.gain_i) * PROD_I_W'(integ_i);
    prod_d_d = PROD_D_W'(cfg_i.gain_d) * PROD_D_W'(diff_i);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_p_q <= prod_p_d;
      prod_i_q <= prod_i_d;
      prod_d_q <= prod_d_d;
      err_q    <= err_i;
    end
  end

  assign prod_p_o = prod_p_q;
  assign prod_i_o = prod_i_q;
  assign prod_d_o = prod_d_q;
  assign err_o    = err_q;

endmodule
`default_nettype wire

[hw/rtl/pcic_back.sv]
// Back stages: sum and scale, then clamp into the output register.
`default_nettype none
module pcic_back
  import pcic_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       load_sum_i,
  input  wire logic                       load_out_i,
  input  wire pcic_cfg_t                  cfg_i,
  input  wire logic signed [PROD_P_W-1:0] prod_p_i,
  input  wire logic signed [PROD_I_W-1:0] prod_i_i,
  input  wire logic signed [PROD_D_W-1:0] prod_d_i,
  input  wire logic signed [ERR_W-1:0]    err_i,
  output logic signed [OUT_W-1:0]         drive_o,
  output logic signed [ERR_W-1:0]         err_o
);

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] scaled_q, scaled_d;
  logic signed [ERR_W-1:0] err_s_q;
  logic signed [SUM_W-1:0] lo, hi;
  logic signed [OUT_W-1:0] drive_q, drive_d;
  logic signed [ERR_W-1:0] err_out_q;

  always_comb begin
    sum      = SUM_W'(prod_p_i) + SUM_W'(prod_i_i) + SUM_W'(prod_d_i);
    scaled_d = sum >>> FRAC_BITS;
  end

  // When the limits cross, a value below the low limit takes the low limit and any other value takes the high limit.
  always_comb begin
    lo = SUM_W'(cfg_i.out_min);
    hi = SUM_W'(cfg_i.out_max);
    if (scaled_q < lo) begin
      drive_d = cfg_i.out_min;
    end else if (scaled_q > hi) begin
      drive_d = cfg_i.out_max;
    end else begin
      drive_d = scaled_q[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_sum_i) begin
      scaled_q <= scaled_d;
      err_s_q  <= err_i;
    end
    if (load_out_i) begin
      drive_q   <= drive_d;
      err_out_q <= err_s_q;
    end
  end

  assign drive_o = drive_q;
  assign err_o   = err_out_q;

endmodule
`default_nettype wire

[hw/rtl/pid_controller_periodic_integral_clear.sv]
// Top level of the PID controller with periodic integral clear and output clamp.
`default_nettype none
`include "pid_controller_periodic_integral_clear_macros.svh"
// Each accepted item (measured, setpoint) yields one result (drive, error_now),
// in order. The block is a four-register pipeline: the front stage forms the
// error and the derivative difference and updates the saturating integral and
// the step counter in the cycle the item is accepted, the second stage forms
// the three gain products, the third sums and scales them by an arithmetic
// right shift of FRAC_BITS, and the fourth clamps into the output register.
// Throughput is one item per clock while the output is not stalled; the
// loop through the integral and counter update sets that rate. Each stage
// holds its contents only while the stage after it is full and cannot
// advance, so empty stages close up and the block keeps taking items while a
// finished result waits at the output. Every CLEAR_LIMIT+1st step clears the
// integral and the counter, and that step's drive uses an integral of zero.
// Write the configuration registers (0 gain_p, 1 gain_i, 2 gain_d, 3 out_min,
// 4 out_max) only while no item is in flight; the write port is always ready
// and ignores other indexes.
module pid_controller_periodic_integral_clear
  import pcic_pkg::*;
#(
  parameter int unsigned CLEAR_LIMIT = CLEAR_LIMIT_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // input item channel
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic signed [SAMPLE_W-1:0] measured_i,
  input  wire logic signed [SAMPLE_W-1:0] setpoint_i,
  // result channel
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic signed [OUT_W-1:0]         drive_o,
  output logic signed [ERR_W-1:0]         error_now_o,
  // configuration write channel
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0]       cfg_data_i
);

  pcic_cfg_t cfg;

  // Stage occupancy: front, multiply, sum, output.
  logic v1_q, v2_q, v3_q, v4_q;
  logic v1_d, v2_d, v3_d, v4_d;
  logic rdy1, rdy2, rdy3, rdy4;
  logic accept, ld2, ld3, ld4;

  logic signed [ERR_W-1:0]    err1, err2, err3;
  logic signed [DIFF_W-1:0]   diff1;
  logic signed [INTEG_W-1:0]  integ1;
  logic signed [PROD_P_W-1:0] prod_p;
  logic signed [PROD_I_W-1:0] prod_i;
  logic signed [PROD_D_W-1:0] prod_d;

  // A stage may load when it is empty or its contents move on this cycle.
  always_comb begin
    rdy4   = !v4_q || !out_stall_i;
    rdy3   = !v3_q || rdy4;
    rdy2   = !v2_q || rdy3;
    rdy1   = !v1_q || rdy2;
    accept = in_valid_i && rdy1;
    ld2    = v1_q && rdy2;
    ld3    = v2_q && rdy3;
    ld4    = v3_q && rdy4;
    v1_d   = accept || (v1_q && !ld2);
    v2_d   = ld2 || (v2_q && !ld3);
    v3_d   = ld3 || (v3_q && !ld4);
    v4_d   = ld4 || (v4_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      v4_q <= v4_d;
    end
  end

  assign in_stall_o  = !rdy1;
  assign out_valid_o = v4_q;
  assign cfg_ready_o = 1'b1;

  pcic_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i && cfg_ready_o),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  pcic_front #(
    .CLEAR_LIMIT (CLEAR_LIMIT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .measured_i (measured_i),
    .setpoint_i (setpoint_i),
    .err_o      (err1),
    .diff_o     (diff1),
    .integ_o    (integ1)
  );

  pcic_mult u_mult (
    .clk_i    (clk_i),
    .load_i   (ld2),
    .cfg_i    (cfg),
    .err_i    (err1),
    .diff_i   (diff1),
    .integ_i  (integ1),
    .prod_p_o (prod_p),
    .prod_i_o (prod_i),
    .prod_d_o (prod_d),
    .err_o    (err2)
  );

  pcic_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .load_sum_i (ld3),
    .load_out_i (ld4),
    .cfg_i      (cfg),
    .prod_p_i   (prod_p),
    .prod_i_i   (prod_i),
    .prod_d_i   (prod_d),
    .err_i      (err2),
    .drive_o    (drive_o),
    .err_o      (err3)
  );

  assign error_now_o = err3;

  // An empty output register never holds back the input.
  `PCIC_ASSERT_IMPL(a_no_stall_when_empty, clk_i, rst_ni, !v4_q, !in_stall_o)
  // An accepted item always lands in the front stage.
  `PCIC_ASSERT_NEXT(a_accept_fills, clk_i, rst_ni, accept, v1_q)
  // A taken result with nothing behind it leaves the output empty.
  `PCIC_ASSERT_NEXT(a_drain_empty, clk_i, rst_ni,
                    out_valid_o && !out_stall_i && !v3_q, !out_valid_o)

endmodule
`default_nettype wire

[test/pcic_checker.sv]
`timescale 1ns / 100ps
// Checker for the PID controller: tracks loop state from accepted items and compares results.
module pcic_checker
  import pcic_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic signed [SAMPLE_W-1:0] measured_i,
  input  logic signed [SAMPLE_W-1:0] setpoint_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic signed [OUT_W-1:0]    drive_i,
  input  logic signed [ERR_W-1:0]    error_now_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DAT_W-1:0]       cfg_data_i,
  output int                         fail_count_o,
  output int                         pending_o,
  output int                         results_o,
  output int                         clears_o
);

  localparam int unsigned REPORT_LIMIT = 10;
  localparam longint      INTEG_MAX    = (longint'(1) <<< (INTEG_W - 1)) - 1;
  localparam longint      INTEG_MIN    = -(longint'(1) <<< (INTEG_W - 1));

  typedef struct packed {
    logic signed [OUT_W-1:0] drive;
    logic signed [ERR_W-1:0] error_now;
  } loop_result_t;

  logic signed [GAIN_W-1:0] kp;
  logic signed [GAIN_W-1:0] ki;
  logic signed [GAIN_W-1:0] kd;
  logic signed [OUT_W-1:0]  lim_lo;
  logic signed [OUT_W-1:0]  lim_hi;
  longint                   prev_err;
  longint                   integ;
  int unsigned              steps;
  loop_result_t             expected_q[$];
  int                       fails;
  int                       mismatches;
  int                       results;
  int                       clears;

  // One control step: update error history, integral and step count, form the drive.
  function automatic loop_result_t advance_loop(input logic signed [SAMPLE_W-1:0] meas,
                                                input logic signed [SAMPLE_W-1:0] setp);
    longint       err;
    longint       diff;
    longint       acc;
    longint       total;
    loop_result_t res;
    err  = longint'(setp) - longint'(meas);
    diff = prev_err - err;
    acc  = integ + err;
    if (acc > INTEG_MAX) acc = INTEG_MAX;
    else if (acc < INTEG_MIN) acc = INTEG_MIN;
    // the clear step folds the error in and then wipes integral and count
    if (steps < CLEAR_LIMIT_DEF) begin
      steps++;
      integ = acc;
    end else begin
      steps = 0;
      integ = 0;
      clears++;
    end
    total = longint'(kp) * err + longint'(ki) * integ + longint'(kd) * diff;
    total = total >>> FRAC_BITS_DEF;
    if (total < longint'(lim_lo)) total = longint'(lim_lo);
    else if (total > longint'(lim_hi)) total = longint'(lim_hi);
    prev_err      = err;
    res.drive     = total[OUT_W-1:0];
    res.error_now = err[ERR_W-1:0];
    return res;
  endfunction

  function automatic void flag(input string what, input longint want, input longint got);
    fails++;
    if (mismatches < REPORT_LIMIT)
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    loop_result_t want;
    if (!rst_ni) begin
      kp       = '0;
      ki       = '0;
      kd       = '0;
      lim_lo   = OUT_MIN_RST;
      lim_hi   = OUT_MAX_RST;
      prev_err = 0;
      integ    = 0;
      steps    = 0;
      expected_q.delete();
      fails      = 0;
      mismatches = 0;
      results    = 0;
      clears     = 0;
    end else begin
      if (cfg_valid_i === 1'b1 && cfg_ready_i === 1'b1) begin
        case (cfg_index_i)
          REG_GAIN_P:  kp = cfg_data_i[GAIN_W-1:0];
          REG_GAIN_I:  ki = cfg_data_i[GAIN_W-1:0];
          REG_GAIN_D:  kd = cfg_data_i[GAIN_W-1:0];
          REG_OUT_MIN: lim_lo = cfg_data_i[OUT_W-1:0];
          REG_OUT_MAX: lim_hi = cfg_data_i[OUT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i === 1'b1 && out_stall_i === 1'b0) begin
        results++;
        if (expected_q.size() == 0) begin
          fails++;
          if (mismatches < REPORT_LIMIT)
            $display("%0t: result with nothing expected: drive %0d, error %0d",
                     $time, drive_i, error_now_i);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (drive_i !== want.drive)
            flag("drive", longint'(want.drive), longint'(drive_i));
          if (error_now_i !== want.error_now)
            flag("error_now", longint'(want.error_now), longint'(error_now_i));
        end
      end
      if (in_valid_i === 1'b1 && in_stall_i === 1'b0)
        expected_q.push_back(advance_loop(measured_i, setpoint_i));
    end
    fail_count_o <= fails;
    pending_o    <= expected_q.size();
    results_o    <= results;
    clears_o     <= clears;
  end

endmodule

[test/tb_pid_controller_periodic_integral_clear.sv]
`timescale 1ns / 100ps
// Testbench top: stimulus, pacing and verdict for the PID controller with integral clear.
module tb_pid_controller_periodic_integral_clear;
  import pcic_pkg::*;

  localparam int unsigned RAND_PHASES   = 6;
  localparam int unsigned PHASE_ITEMS   = 250;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam longint      TIMEOUT_NS    = 64'd5_000_000;
  localparam int unsigned IDX_UNUSED_LO = int'(REG_OUT_MAX) + 1;
  localparam int unsigned IDX_UNUSED_HI = (1 << CFG_IDX_W) - 1;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [GAIN_W-1:0]   GAIN_MIN   = {1'b1, {(GAIN_W-1){1'b0}}};
  localparam logic signed [GAIN_W-1:0]   GAIN_MAX   = {1'b0, {(GAIN_W-1){1'b1}}};
  localparam logic signed [GAIN_W-1:0]   GAIN_ONE   = GAIN_W'(1 << FRAC_BITS_DEF);

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] measured_i;
  logic signed [SAMPLE_W-1:0] setpoint_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic signed [OUT_W-1:0]    drive_o;
  logic signed [ERR_W-1:0]    error_now_o;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i;
  logic [CFG_DAT_W-1:0]       cfg_data_i;

  int                         fail_count;
  int                         pending;
  int                         results;
  int                         clear_steps;
  int unsigned                samples_sent;
  int unsigned                settings_used;
  bit                         gaps_on;
  bit                         stalls_on;
  // setpoint held across a stretch of tracking samples
  logic signed [SAMPLE_W-1:0] target;

  pid_controller_periodic_integral_clear u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .measured_i  (measured_i),
    .setpoint_i  (setpoint_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .drive_o     (drive_o),
    .error_now_o (error_now_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // The checker sees the same pins as the block and keeps the verdict count.
  pcic_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .measured_i   (measured_i),
    .setpoint_i   (setpoint_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .drive_i      (drive_o),
    .error_now_i  (error_now_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results),
    .clears_o     (clear_steps)
  );

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake never completes.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Timeout with %0d results still outstanding", pending);
    $display("RESULT: ERROR");
    $finish;
  end

  // Output back-pressure: mostly short stalls, a few long ones. Each
  // stall decision is made at a falling edge, so the level never toggles
  // twice in one step.
  initial begin : stall_gen
    int unsigned hold;
    hold        = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold != 0) begin
        hold--;
      end else if (stalls_on && $urandom_range(0, 99) >= 60) begin
        out_stall_i <= 1'b1;
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Idle cycles ahead of the next item: mostly none, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Present one sample pair and hold it until the block takes it. When no gap
  // is picked, valid simply stays high into the next item.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] meas,
                             input logic signed [SAMPLE_W-1:0] setp);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    measured_i <= meas;
    setpoint_i <= setp;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    samples_sent++;
  endtask

  task automatic stop_samples();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Block until every accepted sample has produced its checked result.
  task automatic wait_drained();
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
  endtask

  // Load all five registers plus one write to an unmapped index, which the
  // block must drop. Random upper data bits above the gain width check masking.
  task automatic apply_settings(input logic signed [GAIN_W-1:0] gp,
                                input logic signed [GAIN_W-1:0] gi,
                                input logic signed [GAIN_W-1:0] gd,
                                input logic signed [OUT_W-1:0]  lo,
                                input logic signed [OUT_W-1:0]  hi);
    write_reg(REG_GAIN_P, {(CFG_DAT_W-GAIN_W)'($urandom), gp});
    write_reg(REG_GAIN_I, {(CFG_DAT_W-GAIN_W)'($urandom), gi});
    write_reg(CFG_IDX_W'($urandom_range(IDX_UNUSED_LO, IDX_UNUSED_HI)), CFG_DAT_W'($urandom));
    write_reg(REG_GAIN_D, {(CFG_DAT_W-GAIN_W)'($urandom), gd});
    write_reg(REG_OUT_MIN, lo);
    write_reg(REG_OUT_MAX, hi);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  function automatic logic signed [GAIN_W-1:0] random_gain();
    case ($urandom_range(0, 9))
      0:       return GAIN_MIN;
      1:       return GAIN_MAX;
      2:       return '0;
      3, 4, 5: return GAIN_W'(int'($urandom_range(0, 1024)) - 512);
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  // Random gains and clamp window; the window is sometimes full range,
  // sometimes inverted (min above max), sometimes tight around zero.
  task automatic random_settings();
    logic signed [OUT_W-1:0] a;
    logic signed [OUT_W-1:0] b;
    logic signed [OUT_W-1:0] lo;
    logic signed [OUT_W-1:0] hi;
    a = OUT_W'($urandom);
    b = OUT_W'($urandom);
    case ($urandom_range(0, 5))
      0: begin
        lo = OUT_MIN_RST;
        hi = OUT_MAX_RST;
      end
      1: begin
        lo = (a > b) ? a : b;
        hi = (a > b) ? b : a;
      end
      2: begin
        lo = -OUT_W'($urandom_range(0, 2000));
        hi = OUT_W'($urandom_range(0, 2000));
      end
      default: begin
        lo = (a > b) ? b : a;
        hi = (a > b) ? a : b;
      end
    endcase
    apply_settings(random_gain(), random_gain(), random_gain(), lo, hi);
  endtask

  // Mostly closed-loop style samples (measurement hovering near a held
  // setpoint), mixed with full-range noise and rail values.
  task automatic send_random_sample();
    logic signed [SAMPLE_W-1:0] meas;
    logic signed [SAMPLE_W-1:0] setp;
    int                         near;
    case ($urandom_range(0, 9))
      0: begin
        meas = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
        setp = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
      end
      1, 2, 3: begin
        meas = SAMPLE_W'($urandom);
        setp = SAMPLE_W'($urandom);
      end
      default: begin
        if ($urandom_range(0, 19) == 0) target = SAMPLE_W'($urandom);
        near = int'(target) + int'($urandom_range(0, 600)) - 300;
        if (near > int'(SAMPLE_MAX)) near = int'(SAMPLE_MAX);
        if (near < int'(SAMPLE_MIN)) near = int'(SAMPLE_MIN);
        meas = SAMPLE_W'(near);
        setp = target;
      end
    endcase
    send_sample(meas, setp);
  endtask

  initial begin : main_seq
    // drive every input to a known level before reset releases
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    measured_i    = '0;
    setpoint_i    = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    gaps_on       = 1'b0;
    stalls_on     = 1'b0;
    target        = '0;
    samples_sent  = 0;
    settings_used = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: zero gains, so the drive stays zero while error tracks.
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    send_sample(16'sd0, 16'sd0);
    send_sample(SAMPLE_MIN, SAMPLE_MAX);
    send_sample(16'sd123, -16'sd77);
    stop_samples();
    wait_drained();

    // Unit P gain, I gain of one LSB, D gain of minus one, full window: rail-to-rail
    // errors of both signs back to back give the largest derivative swings.
    apply_settings(GAIN_ONE, 16'sd1, -GAIN_ONE, OUT_MIN_RST, OUT_MAX_RST);
    send_sample(SAMPLE_MIN, SAMPLE_MAX);
    send_sample(SAMPLE_MAX, SAMPLE_MIN);
    send_sample(SAMPLE_MIN, SAMPLE_MAX);
    send_sample(SAMPLE_MAX, SAMPLE_MAX);
    send_sample(SAMPLE_MIN, SAMPLE_MIN);
    send_sample(16'sd0, SAMPLE_MIN);
    send_sample(SAMPLE_MIN, 16'sd0);
    send_sample(SAMPLE_MAX, 16'sd0);
    send_sample(16'sd0, SAMPLE_MAX);
    send_sample(-16'sd1, 16'sd1);
    stop_samples();
    wait_drained();

    // Extreme gains drive the sum far outside the output range on both sides.
    apply_settings(GAIN_MIN, GAIN_MAX, GAIN_MAX, OUT_MIN_RST, OUT_MAX_RST);
    send_sample(SAMPLE_MAX, SAMPLE_MIN);
    send_sample(SAMPLE_MIN, SAMPLE_MAX);
    send_sample(16'sd1, 16'sd0);
    send_sample(16'sd0, 16'sd0);
    stop_samples();
    wait_drained();

    // Inverted window: the lower limit wins whenever the value falls below it.
    apply_settings(GAIN_ONE, 16'sd0, 16'sd0, 24'sd1000, -24'sd1000);
    send_sample(16'sd5000, -16'sd5000);
    send_sample(-16'sd5000, 16'sd5000);
    send_sample(16'sd0, 16'sd2000);
    stop_samples();
    wait_drained();

    // Random phases. The step count carries across phases, so the run passes
    // through several integral clear steps with varying integral gains.
    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      random_settings();
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      target    = SAMPLE_W'($urandom);
      repeat (PHASE_ITEMS) send_random_sample();
      stop_samples();
      wait_drained();
    end

    // catch any stray result after the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d samples across %0d register settings, with varied gaps and stalls.",
             samples_sent, settings_used);
    $display("Checked %0d results, spanning %0d integral clear steps.", results, clear_steps);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d failures", fail_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
